[rtl/mdns_response_field_extractor_macros.svh]
// Assertion macros for the mDNS response field extractor.
// No dependencies; included by the modules that carry assertions.
`ifndef MDNS_RESPONSE_FIELD_EXTRACTOR_MACROS_SVH
`define MDNS_RESPONSE_FIELD_EXTRACTOR_MACROS_SVH
`ifndef ASSERT_OFF
`define MDNSFE_ASSERT_NEVER(label, clk, rstn, cond) \
	label: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
		else $error("mdnsfe: forbidden condition seen");
`define MDNSFE_ASSERT_IMPL(label, clk, rstn, prop) \
	label: assert property (@(posedge clk) disable iff (!rstn) prop) \
		else $error("mdnsfe: property failed");
`else
`define MDNSFE_ASSERT_NEVER(label, clk, rstn, cond)
`define MDNSFE_ASSERT_IMPL(label, clk, rstn, prop)
`endif
`endif

[rtl/mdnsfe_pkg.sv]
// Shared constants, types and helpers of the mDNS response field extractor.
// No dependencies.
package mdnsfe_pkg;
	localparam int MAX_PACKET_BYTES = 512;
	localparam int NAME_CAPACITY    = 32;
	localparam int OFF_W            = $clog2(MAX_PACKET_BYTES + 1);
	localparam int POS_W            = 17;
	localparam int NAME_LEN_W       = 5;
	localparam int NAME_MAX         = (NAME_CAPACITY - 1 < 31) ? NAME_CAPACITY - 1 : 31;
	localparam int BUF_COUNT        = 8;
	localparam int BUF_ID_W         = $clog2(BUF_COUNT);
	localparam int NAME_RAM_DEPTH   = BUF_COUNT * (2 ** NAME_LEN_W);
	localparam int NAME_RAM_AW      = $clog2(NAME_RAM_DEPTH);
	localparam int HEADER_BYTES     = 12;
	localparam int KEY_LEN          = 5;

	localparam logic [15:0] TYPE_A   = 16'h0001;
	localparam logic [15:0] TYPE_TXT = 16'h0010;
	localparam logic [15:0] TYPE_SRV = 16'h0021;
	localparam logic [7:0]  PTR_MARK = 8'hC0;

	typedef struct packed {
		logic                  found;
		logic [15:0]           port;
		logic [31:0]           addr;
		logic [NAME_LEN_W-1:0] name_len;
		logic [BUF_ID_W-1:0]   buf_id;
	} result_desc_t;

	typedef struct packed {
		logic                   we;
		logic [NAME_RAM_AW-1:0] addr;
		logic [7:0]             data;
	} name_wr_t;

	typedef struct packed {
		logic                   re;
		logic [NAME_RAM_AW-1:0] addr;
	} name_rd_t;

	// Characters of the "name=" key of a TXT entry.
	function automatic logic [7:0] key_char(input logic [2:0] i);
		logic [7:0] c;
		case (i)
			3'd0: c = 8'h6E;
			3'd1: c = 8'h61;
			3'd2: c = 8'h6D;
			3'd3: c = 8'h65;
			3'd4: c = 8'h3D;
			default: c = 8'h00;
		endcase
		return c;
	endfunction
endpackage

[rtl/mdnsfe_ram.sv]
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module mdnsfe_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule

[rtl/mdnsfe_front.sv]
// Front end: parses the packet byte stream on the fly and builds one result request per packet.
// Depends on mdnsfe_pkg and the assertion macro header.
`include "mdns_response_field_extractor_macros.svh"
module mdnsfe_front
	import mdnsfe_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [7:0]           s_tdata,
	input  logic                 s_tlast,
	output logic                 push,
	output result_desc_t         push_desc,
	input  logic                 q_full,
	input  logic [BUF_COUNT-1:0] q_busy,
	output name_wr_t             name_wr
);
	typedef enum logic [2:0] {
		PH_HDR, PH_QNAME, PH_RNAME, PH_RHDR, PH_RDATA, PH_DEAD
	} phase_t;

	phase_t                phase_q;
	logic [OFF_W-1:0]      off_q;
	logic [POS_W-1:0]      target_q;
	logic                  resp_q;
	logic [15:0]           qd_q;
	logic [15:0]           an_q;
	logic [7:0]            ar_hi_q;
	logic [15:0]           questions_left_q;
	logic [16:0]           records_left_q;
	logic [9:0]            idx_q;
	logic [15:0]           rtype_q;
	logic [15:0]           rdlen_q;
	logic [POS_W-1:0]      rec_end_q;
	logic [31:0]           pval_q;
	logic                  txt_on_q;
	logic [POS_W-1:0]      ent_next_q;
	logic [7:0]            ent_n_q;
	logic [7:0]            ent_p_q;
	logic                  pre_ok_q;
	logic                  fp_q, fa_q;
	logic [15:0]           port_q;
	logic [31:0]           addr_q;
	logic                  cand_v_q;
	logic [BUF_ID_W-1:0]   cand_id_q;
	logic [NAME_LEN_W-1:0] cand_len_q;
	logic [BUF_ID_W-1:0]   kept_id_q;
	logic [NAME_LEN_W-1:0] kept_len_q;
	logic [BUF_ID_W-1:0]   w_id_q;

	logic                  acc, hit, is_ptr;
	logic [POS_W-1:0]      o17, nxt1, lbl, ent_end, rec_end_new;
	logic [16:0]           total;
	logic [15:0]           rdlen_new;
	logic                  rd_last, ent_len_byte, ent_data, ent_match, rec_commit;
	logic                  srv_ok, a_ok;
	logic [31:0]           pv_new;
	logic [7:0]            name_off, cut_raw;
	logic [NAME_LEN_W-1:0] name_cut;
	logic                  cv_n, fp_n, fa_n;
	logic [BUF_ID_W-1:0]   cid_n, kid_n, new_w;
	logic [NAME_LEN_W-1:0] clen_n, klen_n;
	logic [15:0]           port_n;
	logic [31:0]           addr_n;
	logic [BUF_COUNT-1:0]  busy;

	assign s_tready = !q_full;
	assign acc      = s_tvalid && s_tready;
	assign o17      = POS_W'(off_q);
	assign hit      = acc && (off_q < OFF_W'(MAX_PACKET_BYTES)) && (o17 == target_q)
		&& (phase_q != PH_DEAD);
	assign nxt1     = o17 + POS_W'(1);
	assign lbl      = o17 + POS_W'(s_tdata) + POS_W'(1);
	assign is_ptr   = (s_tdata & PTR_MARK) == PTR_MARK;
	assign ent_end  = lbl;
	assign total    = 17'(an_q) + 17'({ar_hi_q, s_tdata});
	assign rdlen_new   = {rdlen_q[15:8], s_tdata};
	assign rec_end_new = nxt1 + POS_W'(rdlen_new);

	assign rd_last      = nxt1 == rec_end_q;
	assign ent_len_byte = txt_on_q && (o17 == ent_next_q);
	assign ent_data     = txt_on_q && !ent_len_byte;
	assign ent_match    = hit && (phase_q == PH_RDATA) && ent_data && (nxt1 == ent_next_q)
		&& pre_ok_q && (ent_n_q > 8'(KEY_LEN));
	assign rec_commit   = hit && (phase_q == PH_RDATA) && rd_last;
	assign srv_ok       = (rtype_q == TYPE_SRV) && (rdlen_q >= 16'd6);
	assign a_ok         = (rtype_q == TYPE_A) && (rdlen_q == 16'd4);
	assign name_off     = ent_p_q - 8'(KEY_LEN);
	assign cut_raw      = ent_n_q - 8'(KEY_LEN);
	assign name_cut     = (cut_raw > 8'(NAME_MAX)) ? NAME_LEN_W'(NAME_MAX)
		: cut_raw[NAME_LEN_W-1:0];

	always_comb begin
		pv_new = pval_q;
		if (rtype_q == TYPE_SRV) begin
			if (idx_q == 10'd4) pv_new[15:8] = s_tdata;
			if (idx_q == 10'd5) pv_new[7:0]  = s_tdata;
		end else if (rtype_q == TYPE_A) begin
			pv_new = {pval_q[23:0], s_tdata};
		end
	end

	// Results as they stand after this byte
	always_comb begin
		cv_n   = ent_match ? 1'b1 : cand_v_q;
		cid_n  = ent_match ? w_id_q : cand_id_q;
		clen_n = ent_match ? name_cut : cand_len_q;
		port_n = (rec_commit && srv_ok) ? pv_new[15:0] : port_q;
		fp_n   = (rec_commit && srv_ok) ? 1'b1 : fp_q;
		addr_n = (rec_commit && a_ok) ? pv_new : addr_q;
		fa_n   = (rec_commit && a_ok) ? 1'b1 : fa_q;
		klen_n = (rec_commit && cv_n) ? clen_n : kept_len_q;
		kid_n  = (rec_commit && cv_n) ? cid_n : kept_id_q;
	end

	// Pick a name buffer that nobody holds
	always_comb begin
		busy = q_busy;
		busy[w_id_q] = 1'b1;
		if (cand_v_q) busy[cand_id_q] = 1'b1;
		if (kept_len_q != '0) busy[kept_id_q] = 1'b1;
		new_w = w_id_q;
		for (int i = BUF_COUNT - 1; i >= 0; i--) begin
			if (!busy[i]) new_w = BUF_ID_W'(i);
		end
	end

	always_comb begin
		name_wr.we   = hit && (phase_q == PH_RDATA) && ent_data
			&& (ent_p_q >= 8'(KEY_LEN)) && (name_off < 8'(NAME_MAX));
		name_wr.addr = {w_id_q, name_off[NAME_LEN_W-1:0]};
		name_wr.data = s_tdata;
	end

	assign push      = acc && s_tlast;
	assign push_desc = '{found: fp_n && fa_n, port: port_n, addr: addr_n,
		name_len: klen_n, buf_id: kid_n};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q          <= PH_HDR;
			off_q            <= '0;
			target_q         <= '0;
			resp_q           <= 1'b0;
			qd_q             <= '0;
			an_q             <= '0;
			ar_hi_q          <= '0;
			questions_left_q <= '0;
			records_left_q   <= '0;
			idx_q            <= '0;
			rtype_q          <= '0;
			rdlen_q          <= '0;
			rec_end_q        <= '0;
			pval_q           <= '0;
			txt_on_q         <= 1'b0;
			ent_next_q       <= '0;
			ent_n_q          <= '0;
			ent_p_q          <= '0;
			pre_ok_q         <= 1'b0;
			fp_q             <= 1'b0;
			fa_q             <= 1'b0;
			port_q           <= '0;
			addr_q           <= '0;
			cand_v_q         <= 1'b0;
			cand_id_q        <= '0;
			cand_len_q       <= '0;
			kept_id_q        <= '0;
			kept_len_q       <= '0;
			w_id_q           <= '0;
		end else begin
			if (acc && (off_q < OFF_W'(MAX_PACKET_BYTES))) begin
				off_q <= off_q + OFF_W'(1);
			end
			if (hit) begin
				unique case (phase_q)
					PH_HDR: begin
						target_q <= nxt1;
						case (off_q[3:0])
							4'd2:  resp_q        <= s_tdata[7];
							4'd4:  qd_q[15:8]    <= s_tdata;
							4'd5:  qd_q[7:0]     <= s_tdata;
							4'd6:  an_q[15:8]    <= s_tdata;
							4'd7:  an_q[7:0]     <= s_tdata;
							4'd10: ar_hi_q       <= s_tdata;
							default: ;
						endcase
						if (o17 == POS_W'(HEADER_BYTES - 1)) begin
							records_left_q   <= total;
							questions_left_q <= qd_q;
							if (!resp_q || total == '0) phase_q <= PH_DEAD;
							else if (qd_q == '0)        phase_q <= PH_RNAME;
							else                        phase_q <= PH_QNAME;
						end
					end
					PH_QNAME: begin
						if (s_tdata == 8'd0 || is_ptr) begin
							// name end plus type and class
							target_q <= (s_tdata == 8'd0) ? o17 + POS_W'(5) : o17 + POS_W'(6);
							questions_left_q <= questions_left_q - 16'd1;
							if (questions_left_q == 16'd1) phase_q <= PH_RNAME;
						end else begin
							target_q <= lbl;
						end
					end
					PH_RNAME: begin
						idx_q <= '0;
						if (s_tdata == 8'd0) begin
							target_q <= nxt1;
							phase_q  <= PH_RHDR;
						end else if (is_ptr) begin
							target_q <= o17 + POS_W'(2);
							phase_q  <= PH_RHDR;
						end else begin
							target_q <= lbl;
						end
					end
					PH_RHDR: begin
						target_q <= nxt1;
						idx_q    <= idx_q + 10'd1;
						case (idx_q[3:0])
							4'd0: rtype_q[15:8] <= s_tdata;
							4'd1: rtype_q[7:0]  <= s_tdata;
							4'd8: rdlen_q[15:8] <= s_tdata;
							default: ;
						endcase
						if (idx_q == 10'd9) begin
							rdlen_q    <= rdlen_new;
							rec_end_q  <= rec_end_new;
							idx_q      <= '0;
							pval_q     <= '0;
							txt_on_q   <= (rtype_q == TYPE_TXT) && (rdlen_new > 16'd1);
							ent_next_q <= nxt1;
							if (rdlen_new == '0) begin
								records_left_q <= records_left_q - 17'd1;
								cand_v_q       <= 1'b0;
								phase_q <= (records_left_q == 17'd1) ? PH_DEAD : PH_RNAME;
							end else begin
								phase_q <= PH_RDATA;
							end
						end
					end
					PH_RDATA: begin
						target_q <= nxt1;
						idx_q    <= idx_q + 10'd1;
						pval_q   <= pv_new;
						if (ent_len_byte) begin
							if (ent_end > rec_end_q) begin
								txt_on_q <= 1'b0;
							end else begin
								ent_n_q    <= s_tdata;
								ent_p_q    <= '0;
								pre_ok_q   <= 1'b1;
								ent_next_q <= ent_end;
							end
						end else if (ent_data) begin
							ent_p_q <= ent_p_q + 8'd1;
							if (ent_p_q < 8'(KEY_LEN)) begin
								pre_ok_q <= pre_ok_q && (s_tdata == key_char(ent_p_q[2:0]));
							end
						end
						cand_v_q   <= cv_n;
						cand_id_q  <= cid_n;
						cand_len_q <= clen_n;
						if (ent_match) w_id_q <= new_w;
						if (rd_last) begin
							port_q         <= port_n;
							fp_q           <= fp_n;
							addr_q         <= addr_n;
							fa_q           <= fa_n;
							kept_len_q     <= klen_n;
							kept_id_q      <= kid_n;
							cand_v_q       <= 1'b0;
							txt_on_q       <= 1'b0;
							records_left_q <= records_left_q - 17'd1;
							phase_q <= (records_left_q == 17'd1) ? PH_DEAD : PH_RNAME;
						end
					end
					PH_DEAD: ;
					default: ;
				endcase
			end
			// Packet end: restart for the next packet
			if (push) begin
				phase_q    <= PH_HDR;
				off_q      <= '0;
				target_q   <= '0;
				resp_q     <= 1'b0;
				txt_on_q   <= 1'b0;
				fp_q       <= 1'b0;
				fa_q       <= 1'b0;
				port_q     <= '0;
				addr_q     <= '0;
				cand_v_q   <= 1'b0;
				kept_len_q <= '0;
			end
		end
	end

	`MDNSFE_ASSERT_NEVER(a_push_full, clk, arst_n, push && q_full)
	`MDNSFE_ASSERT_NEVER(a_wr_queued_buf, clk, arst_n, name_wr.we && q_busy[w_id_q])
	`MDNSFE_ASSERT_NEVER(a_entry_in_record, clk, arst_n,
		txt_on_q && (phase_q == PH_RDATA) && (ent_next_q > rec_end_q))
endmodule

[rtl/mdnsfe_queue.sv]
// Two-entry request queue between the parser front end and the result back end.
// Depends on mdnsfe_pkg.
module mdnsfe_queue
	import mdnsfe_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  result_desc_t         push_desc,
	output logic                 full,
	output logic [BUF_COUNT-1:0] busy,
	output result_desc_t         head,
	output logic                 head_valid,
	input  logic                 pop
);
	result_desc_t ent_q [2];
	logic [1:0]   vld_q;
	logic         wr_ptr_q, rd_ptr_q;

	assign full       = &vld_q;
	assign head       = ent_q[rd_ptr_q];
	assign head_valid = vld_q[rd_ptr_q];

	// Name buffers still referenced by queued requests
	always_comb begin
		busy = '0;
		for (int i = 0; i < 2; i++) begin
			if (vld_q[i] && ent_q[i].name_len != '0) busy[ent_q[i].buf_id] = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
		end else begin
			if (pop) begin
				vld_q[rd_ptr_q] <= 1'b0;
				rd_ptr_q        <= !rd_ptr_q;
			end
			if (push) begin
				vld_q[wr_ptr_q] <= 1'b1;
				wr_ptr_q        <= !wr_ptr_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q] <= push_desc;
		end
	end
endmodule

[rtl/mdnsfe_back.sv]
// Back end: expands each request into a run of result items, reading name bytes from RAM.
// Depends on mdnsfe_pkg and the assertion macro header.
`include "mdns_response_field_extractor_macros.svh"
module mdnsfe_back
	import mdnsfe_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  result_desc_t head,
	input  logic         head_valid,
	output logic         pop,
	output name_rd_t     name_rd,
	input  logic [7:0]   rd_data,
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [63:0]  m_tdata,
	output logic         m_tlast
);
	logic [NAME_LEN_W-1:0] k_q;
	logic [NAME_LEN_W-1:0] runlen;
	logic                  last_item, issue, out_free;
	logic                  rd_s1_q, last_s1;
	result_desc_t          desc_s1;
	logic                  m_tvalid_q;

	assign runlen    = (head.name_len == '0) ? NAME_LEN_W'(1) : head.name_len;
	assign last_item = ({1'b0, k_q} + 6'd1) == {1'b0, runlen};
	assign out_free  = !m_tvalid_q || m_tready;
	assign issue     = head_valid && (!rd_s1_q || out_free);
	assign pop       = issue && last_item;
	assign m_tvalid  = m_tvalid_q;

	always_comb begin
		name_rd.re   = issue;
		name_rd.addr = {head.buf_id, k_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q        <= '0;
			rd_s1_q    <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (issue) begin
				k_q <= last_item ? '0 : k_q + NAME_LEN_W'(1);
			end
			rd_s1_q <= issue || (rd_s1_q && !out_free);
			if (rd_s1_q && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			desc_s1 <= head;
			last_s1 <= last_item;
		end
		if (rd_s1_q && out_free) begin
			m_tdata <= {2'b00, (desc_s1.name_len != '0) ? rd_data : 8'h00, desc_s1.name_len,
				desc_s1.addr, desc_s1.port, desc_s1.found};
			m_tlast <= last_s1;
		end
	end

	`MDNSFE_ASSERT_NEVER(a_pop_empty, clk, arst_n, pop && !head_valid)
	`MDNSFE_ASSERT_NEVER(a_index_range, clk, arst_n, head_valid && (k_q >= runlen))
	`MDNSFE_ASSERT_IMPL(a_hold_read, clk, arst_n, rd_s1_q && !out_free |=> rd_s1_q)
endmodule

[rtl/mdns_response_field_extractor.sv]
// Top level of the mDNS response field extractor: parser front end, request queue,
// result back end and the name buffer RAM. Depends on mdnsfe_pkg and all mdnsfe_* modules.
//
//   channel | dir | payload
//   s_*     | in  | tdata[7:0] data_byte, tlast last_byte
//   m_*     | out | tdata found, service_port, ipv4_address, name_length, name_char; tlast run_end
//
// One packet byte per cycle is taken; bytes are parsed as they stream past.
// At the last byte a request is queued; the back end emits one item per cycle while m_tready is high,
// max(name_length, 1) items, reading one name byte a cycle from the buffer RAM.
// Input stalls only while two result requests are already queued.
// Asynchronous reset clears all control state; no clearing pass is needed.
module mdns_response_field_extractor
	import mdnsfe_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,  // [7:0] data_byte
	input  logic        s_tlast,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata,  // [0] found, [16:1] service_port, [48:17] ipv4_address,
	                              // [53:49] name_length, [61:54] name_char, [63:62] zero
	output logic        m_tlast
);
	logic                 push, q_full, head_valid, pop;
	result_desc_t         push_desc, head;
	logic [BUF_COUNT-1:0] q_busy;
	name_wr_t             name_wr;
	name_rd_t             name_rd;
	logic [7:0]           rd_data;

	mdnsfe_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.push      (push),
		.push_desc (push_desc),
		.q_full    (q_full),
		.q_busy    (q_busy),
		.name_wr   (name_wr)
	);

	mdnsfe_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_desc  (push_desc),
		.full       (q_full),
		.busy       (q_busy),
		.head       (head),
		.head_valid (head_valid),
		.pop        (pop)
	);

	mdnsfe_ram #(
		.WIDTH (8),
		.DEPTH (NAME_RAM_DEPTH)
	) u_name_ram (
		.clk   (clk),
		.we    (name_wr.we),
		.waddr (name_wr.addr),
		.wdata (name_wr.data),
		.re    (name_rd.re),
		.raddr (name_rd.addr),
		.rdata (rd_data)
	);

	mdnsfe_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.head_valid (head_valid),
		.pop        (pop),
		.name_rd    (name_rd),
		.rd_data    (rd_data),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tlast    (m_tlast)
	);
endmodule

[test/mdns_response_field_extractor_checker.sv]
// Checker for the mDNS response field extractor: watches both stream channels,
// predicts the result run of each packet and compares. Depends on mdnsfe_pkg.
`timescale 1ns / 1ps
module mdns_response_field_extractor_checker
	import mdnsfe_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [7:0]  s_tdata,
	input  logic        s_tlast,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [63:0] m_tdata,
	input  logic        m_tlast,
	output int          fail_count,
	output int          pending_items,
	output int          runs_seen
);
	typedef struct packed {
		logic        found;
		logic [15:0] port;
		logic [31:0] addr;
		logic [4:0]  name_len;
		logic [7:0]  name_char;
		logic        run_end;
	} result_item_t;

	logic [7:0]   pkt_bytes [MAX_PACKET_BYTES];
	int           pkt_len;
	result_item_t expected_items [$];

	logic         p_port_ok, p_addr_ok;
	logic [15:0]  p_port;
	logic [31:0]  p_addr;
	logic [7:0]   p_name [32];
	int           p_name_len;

	assign pending_items = expected_items.size();

	function automatic int read16(int pos);
		return (int'(pkt_bytes[pos]) << 8) | int'(pkt_bytes[pos + 1]);
	endfunction

	function automatic int skip_label_name(int pos, int len);
		while (pos < len && pkt_bytes[pos] != 8'd0) begin
			if ((pkt_bytes[pos] & PTR_MARK) == PTR_MARK)
				return pos + 2;
			pos += int'(pkt_bytes[pos]) + 1;
			if (pos >= len)
				return pos;
		end
		if (pos < len)
			pos++;
		return pos;
	endfunction

	task automatic scan_txt_entries(int pos, int stop);
		int n;
		int nl;
		while (pos < stop) begin
			n = int'(pkt_bytes[pos]);
			pos++;
			if (pos + n > stop)
				break;
			if (n > KEY_LEN && pkt_bytes[pos] == "n" && pkt_bytes[pos+1] == "a"
					&& pkt_bytes[pos+2] == "m" && pkt_bytes[pos+3] == "e"
					&& pkt_bytes[pos+4] == "=") begin
				nl = n - KEY_LEN;
				if (nl > NAME_MAX)
					nl = NAME_MAX;
				for (int k = 0; k < nl; k++)
					p_name[k] = pkt_bytes[pos + KEY_LEN + k];
				p_name_len = nl;
			end
			pos += n;
		end
	endtask

	task automatic extract_fields(int len);
		int total, qd, pos, rtype, rdlen;
		p_port_ok = 1'b0;
		p_addr_ok = 1'b0;
		p_port = '0;
		p_addr = '0;
		p_name_len = 0;
		if (len < HEADER_BYTES || !pkt_bytes[2][7])
			return;
		total = read16(6) + read16(10);
		if (total == 0)
			return;
		pos = HEADER_BYTES;
		qd = read16(4);
		for (int q = 0; q < qd && pos < len; q++)
			pos = skip_label_name(pos, len) + 4;
		for (int r = 0; r < total && pos + 10 < len; r++) begin
			pos = skip_label_name(pos, len);
			if (pos + 10 > len)
				break;
			rtype = read16(pos);
			rdlen = read16(pos + 8);
			pos += 10;
			if (pos + rdlen > len)
				break;
			if (rtype == int'(TYPE_SRV) && rdlen >= 6) begin
				p_port = 16'(read16(pos + 4));
				p_port_ok = 1'b1;
			end else if (rtype == int'(TYPE_A) && rdlen == 4) begin
				p_addr = {pkt_bytes[pos], pkt_bytes[pos+1], pkt_bytes[pos+2], pkt_bytes[pos+3]};
				p_addr_ok = 1'b1;
			end else if (rtype == int'(TYPE_TXT) && rdlen > 1) begin
				scan_txt_entries(pos, pos + rdlen);
			end
			pos += rdlen;
		end
	endtask

	task automatic queue_result_run();
		result_item_t it;
		int n;
		extract_fields(pkt_len);
		n = (p_name_len != 0) ? p_name_len : 1;
		for (int k = 0; k < n; k++) begin
			it.found     = p_port_ok && p_addr_ok;
			it.port      = p_port;
			it.addr      = p_addr;
			it.name_len  = p_name_len[4:0];
			it.name_char = (p_name_len != 0) ? p_name[k] : 8'd0;
			it.run_end   = (k + 1 == n);
			expected_items.push_back(it);
		end
	endtask

	task automatic report_mismatch(string what, longint got, longint want);
		$display("mismatch %0t: %s got %0h expected %0h", $time, what, got, want);
		fail_count++;
	endtask

	initial begin
		fail_count = 0;
		pkt_len = 0;
		runs_seen = 0;
	end

	always @(posedge clk) begin
		result_item_t w;
		if (arst_n && s_tvalid && s_tready) begin
			if (pkt_len < MAX_PACKET_BYTES) begin
				pkt_bytes[pkt_len] = s_tdata;
				pkt_len++;
			end
			if (s_tlast) begin
				queue_result_run();
				pkt_len = 0;
			end
		end
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_items.size() == 0) begin
				report_mismatch("unexpected item", m_tdata, 0);
			end else begin
				w = expected_items.pop_front();
				if (m_tdata[0] !== w.found)
					report_mismatch("found", m_tdata[0], w.found);
				if (m_tdata[16:1] !== w.port)
					report_mismatch("service_port", m_tdata[16:1], w.port);
				if (m_tdata[48:17] !== w.addr)
					report_mismatch("ipv4_address", m_tdata[48:17], w.addr);
				if (m_tdata[53:49] !== w.name_len)
					report_mismatch("name_length", m_tdata[53:49], w.name_len);
				if (m_tdata[61:54] !== w.name_char)
					report_mismatch("name_char", m_tdata[61:54], w.name_char);
				if (m_tdata[63:62] !== 2'b00)
					report_mismatch("pad bits", m_tdata[63:62], 0);
				if (m_tlast !== w.run_end)
					report_mismatch("run_end", m_tlast, w.run_end);
				if (w.run_end)
					runs_seen++;
			end
		end
	end
endmodule

[test/tb.sv]
// Stimulus top for the mDNS response field extractor: builds response packets,
// streams them under varied idling and gives the verdict. Depends on the checker.
`timescale 1ns / 1ps
module tb
	import mdnsfe_pkg::*;
();
	localparam int STALL_LIMIT = 20000;

	logic        clk = 0;
	logic        arst_n = 0;
	logic        s_tvalid = 0;
	logic        s_tready;
	logic [7:0]  s_tdata = '0;
	logic        s_tlast = 0;
	logic        m_tvalid;
	logic        m_tready = 0;
	logic [63:0] m_tdata;
	logic        m_tlast;
	int          fail_count, pending_items, runs_seen;
	int          send_idle_pct = 0, recv_stall_pct = 0;
	int          idle_cycles = 0, packets_sent = 0;
	logic [7:0]  pkt [$];

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	mdns_response_field_extractor i_dut (.*);

	mdns_response_field_extractor_checker i_checker (.*);

	always @(posedge clk) begin
		if ($urandom_range(99) < recv_stall_pct)
			m_tready <= 1'b0;
		else
			m_tready <= 1'b1;
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
	end

	always @(posedge clk) begin
		if (idle_cycles >= STALL_LIMIT) begin
			$display("watchdog: no progress, %0d results outstanding", pending_items);
			$display("TB_ERROR");
			$finish;
		end
	end

	task automatic push16(int v);
		pkt.push_back(v[15:8]);
		pkt.push_back(v[7:0]);
	endtask

	task automatic push_header(int flags, int qd, int an, int ar);
		push16($urandom);
		push16(flags);
		push16(qd);
		push16(an);
		push16(0);
		push16(ar);
	endtask

	task automatic push_name(bit use_ptr);
		int n = $urandom_range(3);
		for (int i = 0; i < n; i++) begin
			int l = $urandom_range(1, 6);
			pkt.push_back(8'(l));
			for (int j = 0; j < l; j++)
				pkt.push_back(8'($urandom_range(97, 122)));
		end
		if (use_ptr) begin
			pkt.push_back(PTR_MARK | 8'($urandom_range(63)));
			pkt.push_back(8'($urandom));
		end else begin
			pkt.push_back(8'd0);
		end
	endtask

	task automatic push_rr_head(logic [15:0] rtype, int rdlen);
		push_name(1'($urandom_range(1)));
		push16(int'(rtype));
		push16(1);
		push16($urandom);
		push16($urandom);
		push16(rdlen);
	endtask

	task automatic push_txt(int name_len);
		int entries[$];
		int total = 0;
		entries.push_back($urandom_range(0, 4));
		entries.push_back(name_len + KEY_LEN);
		foreach (entries[i])
			total += entries[i] + 1;
		push_rr_head(TYPE_TXT, total);
		pkt.push_back(8'(entries[0]));
		for (int j = 0; j < entries[0]; j++)
			pkt.push_back(8'($urandom));
		pkt.push_back(8'(entries[1]));
		pkt.push_back("n"); pkt.push_back("a"); pkt.push_back("m");
		pkt.push_back("e"); pkt.push_back("=");
		for (int j = 0; j < name_len; j++)
			pkt.push_back(8'($urandom));
	endtask

	// Build a well-formed response with random records, sometimes broken.
	task automatic build_response(int name_len);
		int qd = $urandom_range(2);
		int nrec = $urandom_range(1, 4);
		push_header(16'h8400 | ($urandom & 16'h7BFF), qd, nrec - 1, 1);
		for (int q = 0; q < qd; q++) begin
			push_name(1'($urandom_range(1)));
			push16($urandom);
			push16($urandom);
		end
		for (int r = 0; r < nrec; r++) begin
			case ($urandom_range(5))
				0, 1: begin
					push_rr_head(TYPE_SRV, 6 + $urandom_range(1) * 2);
					repeat (4) pkt.push_back(8'($urandom));
					push16($urandom);
				end
				2, 3: begin
					push_rr_head(TYPE_A, ($urandom_range(7) == 0) ? 5 : 4);
					repeat (4) pkt.push_back(8'($urandom));
				end
				4: push_txt(name_len);
				default: begin
					push_rr_head(16'($urandom), 2);
					repeat (2) pkt.push_back(8'($urandom));
				end
			endcase
		end
		if ($urandom_range(9) == 0)
			repeat ($urandom_range(1, 20)) void'(pkt.pop_back());
	endtask

	// Leave valid up after the last byte; the next packet or the drain drops it
	task automatic send_packet();
		if (pkt.size() == 0)
			pkt.push_back(8'($urandom));
		foreach (pkt[i]) begin
			while ($urandom_range(99) < send_idle_pct) begin
				s_tvalid <= 1'b0;
				@(posedge clk);
			end
			s_tvalid <= 1'b1;
			s_tdata  <= pkt[i];
			s_tlast  <= (i == pkt.size() - 1);
			@(posedge clk);
			while (!s_tready)
				@(posedge clk);
		end
		pkt.delete();
		packets_sent++;
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		s_tlast  <= 1'b0;
		@(posedge clk);
		while (pending_items != 0)
			@(posedge clk);
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Short packets, non-responses, zero record count, one-byte packet.
		pkt.push_back(8'hFF);
		send_packet();
		repeat (11) pkt.push_back(8'($urandom));
		send_packet();
		push_header(16'h0000, 0, 1, 0);
		send_packet();
		push_header(16'hFFFF, 0, 0, 0);
		send_packet();
		// Record count summing above 16 bits, then truncated.
		push_header(16'h8000, 0, 16'hFFFF, 16'hFFFF);
		pkt.push_back(8'd0);
		send_packet();
		// Maximal name, long name truncation, one-character name.
		build_response(NAME_MAX);
		send_packet();
		build_response(40);
		send_packet();
		build_response(1);
		send_packet();
		// SRV plus A with all-ones fields.
		push_header(16'h8000, 0, 2, 0);
		push_rr_head(TYPE_SRV, 6);
		repeat (6) pkt.push_back(8'hFF);
		push_rr_head(TYPE_A, 4);
		repeat (4) pkt.push_back(8'hFF);
		send_packet();
		// Overlong packet: last mark beyond the store.
		build_response(3);
		while (pkt.size() < MAX_PACKET_BYTES + 20)
			pkt.push_back(8'($urandom));
		send_packet();
		wait_drained();

		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 56; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 56; end
				default: begin send_idle_pct = 25; recv_stall_pct = 25; end
			endcase
			for (int n = 0; n < 25; n++) begin
				if ($urandom_range(7) == 0) begin
					repeat ($urandom_range(1, 30)) pkt.push_back(8'($urandom));
				end else begin
					build_response($urandom_range(9) == 0 ? $urandom_range(25, 40)
						: $urandom_range(1, 8));
				end
				send_packet();
			end
			wait_drained();
		end

		repeat (50) @(posedge clk);
		$display("covered %0d packets, %0d result runs, under four idling mixes",
			packets_sent, runs_seen);
		if (fail_count == 0 && pending_items == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end
endmodule
